[rtl/core/psd_pkg.sv]
package psd_pkg;

  localparam int unsigned PtsWidth = 23;
  localparam int unsigned DivInWidth = 30;
  localparam int unsigned RecipWidth = 31;
  localparam int unsigned RecipShift = 38;
  localparam logic [RecipWidth-1:0] Recip225 = 31'd1221679587;

  localparam logic [7:0] CodeEnd     = 8'hb9;
  localparam logic [7:0] CodePack    = 8'hba;
  localparam logic [7:0] CodePriv1   = 8'hbd;
  localparam logic [7:0] CodePadding = 8'hbe;

  typedef enum logic [2:0] {
    KIND_PAYLOAD = 3'd0,
    KIND_PACKVER = 3'd1,
    KIND_HDRLEN  = 3'd2,
    KIND_UNKNOWN = 3'd3,
    KIND_MPEG1   = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t                kind;
    logic [7:0]           payload_byte;
    logic [7:0]           stream_id;
    logic [PtsWidth-1:0]  pts_centis;
    logic                 pts_marker_bad;
    logic                 last_of_packet;
  } result_t;

  typedef struct packed {
    logic                  go;
    logic                  markers_ok;
    logic [DivInWidth-1:0] ticks_div4;
  } div_req_t;

endpackage

[rtl/core/psd_pts_div.sv]
module psd_pts_div (
  input  logic                              clk,
  input  logic                              rst,
  input  psd_pkg::div_req_t                 req,
  output logic [psd_pkg::PtsWidth-1:0]      pts_centis,
  output logic                              pts_marker_bad
);

  logic [psd_pkg::DivInWidth-1:0] ticks;
  logic                           mul_go;
  logic [psd_pkg::DivInWidth+psd_pkg::RecipWidth-1:0] prod;
  logic                           bad;

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_go <= 1'b0;
      bad    <= 1'b0;
      prod   <= '0;
    end else begin
      mul_go <= req.go && req.markers_ok;
      if (req.go) begin
        bad <= !req.markers_ok;
      end
      if (mul_go) begin
        prod <= ticks * psd_pkg::Recip225;
      end
    end
    if (req.go) begin
      ticks <= req.ticks_div4;
    end
  end

  assign pts_centis = bad ? '0 :
    prod[psd_pkg::RecipShift +: psd_pkg::PtsWidth];
  assign pts_marker_bad = bad;

endmodule

[rtl/core/psd_parser.sv]
module psd_parser (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_fire,
  input  logic [7:0]                    data_byte,
  input  logic [psd_pkg::PtsWidth-1:0]  pts_centis,
  input  logic                          pts_marker_bad,
  output logic                          push,
  output psd_pkg::result_t              item,
  output psd_pkg::div_req_t             div_req
);

  typedef enum logic [4:0] {
    HUNT, PACKVER, SKIP, SKLEN_HI, SKLEN_LO, PLEN_HI, PLEN_LO, PFIRST, STD,
    AFTERSTD, FLAGS, HDRLEN, PTS0, PTS1, PTS2, PTS3, PTS4, HDRSKIP, SUBID, PAYLOAD
  } phase_t;

  phase_t      phase, phase_next;
  logic [23:0] sync, sync_next;
  logic [15:0] pkt_rem, pkt_rem_next;
  logic [7:0]  hdr_rem, hdr_rem_next;
  logic [7:0]  flags, flags_next;
  logic [31:0] pts_bytes, pts_bytes_next;
  logic [7:0]  sub, sub_next;
  logic        emit;
  psd_pkg::kind_t kind;
  logic        last;
  logic [9:0]  need;
  logic        has_pts;
  logic [31:0] ticks;
  logic        markers_ok;
  logic        div_go;

  assign has_pts = flags[7:6] == 2'b10;
  assign need = {2'b00, hdr_rem} + 10'd2 + {2'b00, data_byte};
  assign ticks = {pts_bytes[26:25], pts_bytes[23:16], pts_bytes[15:9],
                  pts_bytes[7:0], data_byte[7:1]};
  assign markers_ok = (pts_bytes[31:28] == 4'h2) && pts_bytes[24] &&
                      pts_bytes[8] && data_byte[0];

  always_comb begin
    phase_next     = phase;
    sync_next      = sync;
    pkt_rem_next   = pkt_rem;
    hdr_rem_next   = hdr_rem;
    flags_next     = flags;
    pts_bytes_next = pts_bytes;
    sub_next       = sub;
    emit           = 1'b0;
    kind           = psd_pkg::KIND_PAYLOAD;
    last           = 1'b0;
    div_go         = 1'b0;
    if (in_fire) begin
      unique case (phase)
        HUNT: begin
          if (sync != 24'h000001) begin
            sync_next = {sync[15:0], data_byte};
          end else begin
            sync_next = 24'hffffff;
            if (data_byte == psd_pkg::CodeEnd) begin
              phase_next = HUNT;
            end else if (data_byte == psd_pkg::CodePack) begin
              phase_next = PACKVER;
            end else if (data_byte == psd_pkg::CodePriv1) begin
              phase_next = PLEN_HI;
            end else if (data_byte == psd_pkg::CodePadding ||
                         (data_byte >= 8'hc0 && data_byte < 8'hf0)) begin
              phase_next = SKLEN_HI;
            end else begin
              emit = 1'b1;
              kind = psd_pkg::KIND_UNKNOWN;
            end
          end
        end
        PACKVER: begin
          if (data_byte[7:6] == 2'b01) begin
            pkt_rem_next = 16'd9;
            phase_next   = SKIP;
          end else if (data_byte[7:4] == 4'h2) begin
            pkt_rem_next = 16'd7;
            phase_next   = SKIP;
          end else begin
            phase_next = HUNT;
            sync_next  = 24'hffffff;
            emit       = 1'b1;
            kind       = psd_pkg::KIND_PACKVER;
          end
        end
        SKIP: begin
          pkt_rem_next = pkt_rem - 16'd1;
          if (pkt_rem == 16'd1) begin
            phase_next = HUNT;
            sync_next  = 24'hffffff;
          end
        end
        SKLEN_HI: begin
          pkt_rem_next = {data_byte, 8'h00};
          phase_next   = SKLEN_LO;
        end
        SKLEN_LO: begin
          pkt_rem_next = {pkt_rem[15:8], data_byte};
          if ({pkt_rem[15:8], data_byte} == 16'd0) begin
            phase_next = HUNT;
            sync_next  = 24'hffffff;
          end else begin
            phase_next = SKIP;
          end
        end
        PLEN_HI: begin
          pkt_rem_next = {data_byte, 8'h00};
          phase_next   = PLEN_LO;
        end
        PLEN_LO: begin
          pkt_rem_next = {pkt_rem[15:8], data_byte};
          phase_next   = PFIRST;
        end
        PFIRST, AFTERSTD: begin
          hdr_rem_next = (phase == PFIRST) ? 8'd1 : 8'd3;
          if (phase == PFIRST && data_byte[7:6] == 2'b01) begin
            phase_next = STD;
          end else if (data_byte[7:5] == 3'b001) begin
            phase_next = HUNT;
            sync_next  = 24'hffffff;
            emit       = 1'b1;
            kind       = psd_pkg::KIND_MPEG1;
          end else if (data_byte[7:6] == 2'b10) begin
            phase_next = FLAGS;
          end else begin
            phase_next = HUNT;
            sync_next  = 24'hffffff;
          end
        end
        STD: begin
          hdr_rem_next = 8'd2;
          phase_next   = AFTERSTD;
        end
        FLAGS: begin
          hdr_rem_next = hdr_rem + 8'd1;
          flags_next   = data_byte;
          phase_next   = HDRLEN;
        end
        HDRLEN: begin
          if ({6'd0, need} > pkt_rem || (has_pts && data_byte < 8'd5)) begin
            phase_next = HUNT;
            sync_next  = 24'hffffff;
            emit       = 1'b1;
            kind       = psd_pkg::KIND_HDRLEN;
          end else begin
            pkt_rem_next = pkt_rem - {8'd0, hdr_rem} - 16'd1;
            hdr_rem_next = data_byte;
            if (has_pts) begin
              phase_next = PTS0;
            end else begin
              phase_next = (data_byte == 8'd0) ? SUBID : HDRSKIP;
            end
          end
        end
        PTS0, PTS1, PTS2, PTS3, PTS4: begin
          pts_bytes_next = {pts_bytes[23:0], data_byte};
          hdr_rem_next   = hdr_rem - 8'd1;
          pkt_rem_next   = pkt_rem - 16'd1;
          if (phase == PTS4) begin
            div_go     = 1'b1;
            phase_next = (hdr_rem == 8'd1) ? SUBID : HDRSKIP;
          end else begin
            phase_next = phase_t'(phase + 5'd1);
          end
        end
        HDRSKIP: begin
          hdr_rem_next = hdr_rem - 8'd1;
          pkt_rem_next = pkt_rem - 16'd1;
          if (hdr_rem == 8'd1) begin
            phase_next = SUBID;
          end
        end
        SUBID: begin
          sub_next     = data_byte;
          pkt_rem_next = pkt_rem - 16'd1;
          if (pkt_rem == 16'd1) begin
            phase_next = HUNT;
            sync_next  = 24'hffffff;
          end else begin
            phase_next = PAYLOAD;
          end
        end
        PAYLOAD: begin
          pkt_rem_next = pkt_rem - 16'd1;
          emit         = 1'b1;
          last         = pkt_rem == 16'd1;
          if (pkt_rem == 16'd1) begin
            phase_next = HUNT;
            sync_next  = 24'hffffff;
          end
        end
        default: begin
          phase_next = HUNT;
          sync_next  = 24'hffffff;
        end
      endcase
    end
  end

  assign div_req = {div_go, markers_ok, ticks[31:2]};

  assign push = emit;
  assign item = {kind,
                 (kind == psd_pkg::KIND_PAYLOAD) ? data_byte : 8'd0,
                 (kind == psd_pkg::KIND_PAYLOAD) ? sub : 8'd0,
                 pts_centis, pts_marker_bad, last};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= HUNT;
      sync      <= 24'hffffff;
      pkt_rem   <= '0;
      hdr_rem   <= '0;
      flags     <= '0;
      pts_bytes <= '0;
      sub       <= '0;
    end else begin
      phase     <= phase_next;
      sync      <= sync_next;
      pkt_rem   <= pkt_rem_next;
      hdr_rem   <= hdr_rem_next;
      flags     <= flags_next;
      pts_bytes <= pts_bytes_next;
      sub       <= sub_next;
    end
  end

endmodule

[rtl/core/psd_fifo.sv]
module psd_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  psd_pkg::result_t wr_item,
  output logic             full,
  output logic             out_valid,
  input  logic             out_ready,
  output psd_pkg::result_t rd_item
);

  psd_pkg::result_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign pop = out_valid && out_ready;
  assign full = count == 2'd2;
  assign out_valid = count != 2'd0;
  assign rd_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
    if (push) begin
      slots[wr_ptr] <= wr_item;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue count out of range");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("push into full queue");
  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0 || count == 2'd2) |-> wr_ptr == rd_ptr)
    else $error("queue pointers disagree with count");
`endif

endmodule

[rtl/core/program_stream_subtitle_demux.sv]
// Subtitle demultiplexer for an MPEG program stream.
// The slave channel takes one stream byte per transaction in s_tdata. The
// master channel gives one result per transaction: m_tuser holds the kind
// (payload or one of four error codes), m_tlast marks the final payload
// byte of a packet, and m_tdata holds payload byte, substream id, time in
// hundredths of a second and the bad-marker flag.
// A byte is parsed in the cycle it is accepted, so one byte per cycle is
// sustained while the queue is not full; a result it causes is queued. The
// time is divided by 900 in a reciprocal multiplier with registered operand
// and product that finishes before the packet's first payload byte arrives.
// A two-entry result queue parts the channels: while results wait, bytes
// keep flowing until the queue is full, and then s_tready drops until the
// receiver takes a result. While the queue is full no byte is taken,
// whether or not it would cause a result.
// Reset starts the start-code hunt with an empty queue and zero time.
module program_stream_subtitle_demux (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // payload_byte, stream_id, pts_centis, pts_marker_bad
  output logic [2:0]  m_tuser,   // kind
  output logic        m_tlast
);

  logic                          in_fire;
  logic                          push;
  logic                          full;
  psd_pkg::result_t              wr_item;
  psd_pkg::result_t              rd_item;
  psd_pkg::div_req_t             div_req;
  logic [psd_pkg::PtsWidth-1:0]  pts_centis;
  logic                          pts_marker_bad;

  assign s_tready = !full;
  assign in_fire = s_tvalid && s_tready;

  psd_parser u_parser (
    .clk            (clk),
    .rst            (rst),
    .in_fire        (in_fire),
    .data_byte      (s_tdata),
    .pts_centis     (pts_centis),
    .pts_marker_bad (pts_marker_bad),
    .push           (push),
    .item           (wr_item),
    .div_req        (div_req)
  );

  psd_pts_div u_div (
    .clk            (clk),
    .rst            (rst),
    .req            (div_req),
    .pts_centis     (pts_centis),
    .pts_marker_bad (pts_marker_bad)
  );

  psd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_item   (wr_item),
    .full      (full),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .rd_item   (rd_item)
  );

  assign m_tdata = {rd_item.pts_marker_bad, rd_item.pts_centis,
                    rd_item.stream_id, rd_item.payload_byte};
  assign m_tuser = rd_item.kind;
  assign m_tlast = rd_item.last_of_packet;

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps

module tb;

  typedef enum logic [4:0] {
    PS_HUNT, PS_PACKVER, PS_SKIP, PS_SKLEN_HI, PS_SKLEN_LO, PS_PLEN_HI, PS_PLEN_LO,
    PS_PFIRST, PS_STD, PS_AFTERSTD, PS_FLAGS, PS_HDRLEN, PS_PTS0, PS_PTS1, PS_PTS2,
    PS_PTS3, PS_PTS4, PS_HDRSKIP, PS_SUBID, PS_PAYLOAD
  } parse_state_t;

  localparam int unsigned TicksPerCentis = 900;

  // Directed rows: {typed expectation, kind, stream byte}.
  localparam int DirRows = 47;
  localparam logic [11:0] DirTab [0:DirRows-1] = '{
    {1'b0, psd_pkg::KIND_PAYLOAD, 8'h00}, {1'b0, psd_pkg::KIND_PAYLOAD, 8'h00},
    {1'b0, psd_pkg::KIND_PAYLOAD, 8'h01},
    {1'b0, psd_pkg::KIND_PAYLOAD, 8'hba}, {1'b1, psd_pkg::KIND_PACKVER, 8'h00},
    {1'b0, psd_pkg::KIND_PAYLOAD, 8'h00}, {1'b0, psd_pkg::KIND_PAYLOAD, 8'h00},
    {1'b0, psd_pkg::KIND_PAYLOAD, 8'h01},
    {1'b1, psd_pkg::KIND_UNKNOWN, 8'hbb},
    {1'b0, psd_pkg::KIND_PAYLOAD, 8'h00}, {1'b0, psd_pkg::KIND_PAYLOAD, 8'h00},
    {1'b0, psd_pkg::KIND_PAYLOAD, 8'h01},
    {1'b0, psd_pkg::KIND_PAYLOAD, 8'hb9},
    {1'b0, psd_pkg::KIND_PAYLOAD, 8'h00}, {1'b0, psd_pkg::KIND_PAYLOAD, 8'h00},
    {1'b0, psd_pkg::KIND_PAYLOAD, 8'h01},
    {1'b0, psd_pkg::KIND_PAYLOAD, 8'hbd}, {1'b0, psd_pkg::KIND_PAYLOAD, 8'h00},
    {1'b0, psd_pkg::KIND_PAYLOAD, 8'h10},
    {1'b1, psd_pkg::KIND_MPEG1,   8'h20},
    {1'b0, psd_pkg::KIND_PAYLOAD, 8'h00}, {1'b0, psd_pkg::KIND_PAYLOAD, 8'h00},
    {1'b0, psd_pkg::KIND_PAYLOAD, 8'h01},
    {1'b0, psd_pkg::KIND_PAYLOAD, 8'hbd}, {1'b0, psd_pkg::KIND_PAYLOAD, 8'h00},
    {1'b0, psd_pkg::KIND_PAYLOAD, 8'h05},
    {1'b0, psd_pkg::KIND_PAYLOAD, 8'h80}, {1'b0, psd_pkg::KIND_PAYLOAD, 8'h80},
    {1'b1, psd_pkg::KIND_HDRLEN,  8'h04},
    {1'b0, psd_pkg::KIND_PAYLOAD, 8'h00}, {1'b0, psd_pkg::KIND_PAYLOAD, 8'h00},
    {1'b0, psd_pkg::KIND_PAYLOAD, 8'h01},
    {1'b0, psd_pkg::KIND_PAYLOAD, 8'hbd}, {1'b0, psd_pkg::KIND_PAYLOAD, 8'h00},
    {1'b0, psd_pkg::KIND_PAYLOAD, 8'h0b},
    {1'b0, psd_pkg::KIND_PAYLOAD, 8'h80}, {1'b0, psd_pkg::KIND_PAYLOAD, 8'h80},
    {1'b0, psd_pkg::KIND_PAYLOAD, 8'h05},
    {1'b0, psd_pkg::KIND_PAYLOAD, 8'h2f}, {1'b0, psd_pkg::KIND_PAYLOAD, 8'hff},
    {1'b0, psd_pkg::KIND_PAYLOAD, 8'hff},
    {1'b0, psd_pkg::KIND_PAYLOAD, 8'hff}, {1'b0, psd_pkg::KIND_PAYLOAD, 8'hff},
    {1'b0, psd_pkg::KIND_PAYLOAD, 8'hff},
    {1'b0, psd_pkg::KIND_PAYLOAD, 8'h00}, {1'b0, psd_pkg::KIND_PAYLOAD, 8'hff},
    {1'b0, psd_pkg::KIND_PAYLOAD, 8'h00}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;

  logic  typed_row = 1'b0;
  psd_pkg::kind_t typed_kind = psd_pkg::KIND_PAYLOAD;

  int idle_pct = 0;
  int stall_pct = 0;
  int bytes_sent = 0;
  bit failed = 1'b0;

  psd_pkg::result_t expected_results [$];
  logic [7:0] pkt_bytes [$];

  parse_state_t st;
  logic [23:0]  window;
  logic [15:0]  pkt_left;
  logic [7:0]   hdr_left;
  logic [7:0]   pes_flags;
  logic [39:0]  pts_raw;
  logic [22:0]  pts_centis;
  logic         pts_bad;
  logic [7:0]   substream;

  program_stream_subtitle_demux DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast)
  );

  always #5 clk = ~clk;

  function automatic psd_pkg::result_t make_result(psd_pkg::kind_t k, logic [7:0] pb,
                                                   logic [7:0] sid, logic last);
    psd_pkg::result_t r;
    r.kind = k;
    r.payload_byte = pb;
    r.stream_id = sid;
    r.pts_centis = pts_centis;
    r.pts_marker_bad = pts_bad;
    r.last_of_packet = last;
    return r;
  endfunction

  task automatic restart_hunt();
    st = PS_HUNT;
    window = 24'hffffff;
  endtask

  task automatic decode_time();
    logic [31:0] ticks;
    if (pts_raw[39:36] == 4'h2 && pts_raw[32] && pts_raw[16] && pts_raw[0]) begin
      ticks = {pts_raw[34:33], 30'd0} | ({24'd0, pts_raw[31:24]} << 22)
            | ({24'd0, pts_raw[23:17], 1'b0} << 14) | ({24'd0, pts_raw[15:8]} << 7)
            | {25'd0, pts_raw[7:1]};
      pts_centis = 23'(ticks / TicksPerCentis);
      pts_bad = 1'b0;
    end else begin
      pts_centis = '0;
      pts_bad = 1'b1;
    end
  endtask

  task automatic classify_first(input logic [7:0] b, output bit got,
                                output psd_pkg::result_t r);
    got = 1'b0;
    r = '0;
    if (b[7:4] == 4'h2 || b[7:4] == 4'h3) begin
      restart_hunt();
      got = 1'b1;
      r = make_result(psd_pkg::KIND_MPEG1, 8'h00, 8'h00, 1'b0);
    end else if (b[7:6] == 2'b10) begin
      st = PS_FLAGS;
    end else begin
      restart_hunt();
    end
  endtask

  task automatic parse_byte(input logic [7:0] b, output bit got, output psd_pkg::result_t r);
    logic [8:0] used;
    bit has_pts;
    got = 1'b0;
    r = '0;
    case (st)
      PS_HUNT: begin
        if (window != 24'h000001) begin
          window = {window[15:0], b};
        end else begin
          window = 24'hffffff;
          if (b == psd_pkg::CodePack) st = PS_PACKVER;
          else if (b == psd_pkg::CodePriv1) st = PS_PLEN_HI;
          else if (b == psd_pkg::CodePadding || (b >= 8'hc0 && b < 8'hf0)) st = PS_SKLEN_HI;
          else if (b != psd_pkg::CodeEnd) begin
            got = 1'b1;
            r = make_result(psd_pkg::KIND_UNKNOWN, 8'h00, 8'h00, 1'b0);
          end
        end
      end
      PS_PACKVER: begin
        if (b[7:6] == 2'b01) begin
          pkt_left = 16'd9;
          st = PS_SKIP;
        end else if (b[7:4] == 4'h2) begin
          pkt_left = 16'd7;
          st = PS_SKIP;
        end else begin
          restart_hunt();
          got = 1'b1;
          r = make_result(psd_pkg::KIND_PACKVER, 8'h00, 8'h00, 1'b0);
        end
      end
      PS_SKIP: begin
        pkt_left = pkt_left - 16'd1;
        if (pkt_left == 16'd0) restart_hunt();
      end
      PS_SKLEN_HI: begin
        pkt_left = {b, 8'h00};
        st = PS_SKLEN_LO;
      end
      PS_SKLEN_LO: begin
        pkt_left = pkt_left | {8'h00, b};
        if (pkt_left == 16'd0) restart_hunt();
        else st = PS_SKIP;
      end
      PS_PLEN_HI: begin
        pkt_left = {b, 8'h00};
        st = PS_PLEN_LO;
      end
      PS_PLEN_LO: begin
        pkt_left = pkt_left | {8'h00, b};
        st = PS_PFIRST;
      end
      PS_PFIRST: begin
        hdr_left = 8'd1;
        if (b[7:6] == 2'b01) st = PS_STD;
        else classify_first(b, got, r);
      end
      PS_STD: begin
        hdr_left = 8'd2;
        st = PS_AFTERSTD;
      end
      PS_AFTERSTD: begin
        hdr_left = 8'd3;
        classify_first(b, got, r);
      end
      PS_FLAGS: begin
        hdr_left = hdr_left + 8'd1;
        pes_flags = b;
        st = PS_HDRLEN;
      end
      PS_HDRLEN: begin
        used = {1'b0, hdr_left} + 9'd1;
        has_pts = pes_flags[7:6] == 2'b10;
        if ({8'd0, used} + {9'd0, b} + 17'd1 > {1'b0, pkt_left} || (has_pts && b < 8'd5)) begin
          restart_hunt();
          got = 1'b1;
          r = make_result(psd_pkg::KIND_HDRLEN, 8'h00, 8'h00, 1'b0);
        end else begin
          pkt_left = pkt_left - {7'd0, used};
          hdr_left = b;
          if (has_pts) st = PS_PTS0;
          else st = (hdr_left == 8'd0) ? PS_SUBID : PS_HDRSKIP;
        end
      end
      PS_PTS0, PS_PTS1, PS_PTS2, PS_PTS3, PS_PTS4: begin
        pts_raw = {pts_raw[31:0], b};
        hdr_left = hdr_left - 8'd1;
        pkt_left = pkt_left - 16'd1;
        if (st == PS_PTS4) begin
          decode_time();
          st = (hdr_left == 8'd0) ? PS_SUBID : PS_HDRSKIP;
        end else begin
          st = parse_state_t'(st + 5'd1);
        end
      end
      PS_HDRSKIP: begin
        hdr_left = hdr_left - 8'd1;
        pkt_left = pkt_left - 16'd1;
        if (hdr_left == 8'd0) st = PS_SUBID;
      end
      PS_SUBID: begin
        substream = b;
        pkt_left = pkt_left - 16'd1;
        if (pkt_left == 16'd0) restart_hunt();
        else st = PS_PAYLOAD;
      end
      PS_PAYLOAD: begin
        pkt_left = pkt_left - 16'd1;
        got = 1'b1;
        r = make_result(psd_pkg::KIND_PAYLOAD, b, substream, pkt_left == 16'd0);
        if (pkt_left == 16'd0) restart_hunt();
      end
      default: restart_hunt();
    endcase
  endtask

  always @(posedge clk) begin
    bit got;
    psd_pkg::result_t r;
    psd_pkg::result_t exp_r;
    if (rst) begin
      restart_hunt();
      pkt_left <= '0;
      hdr_left <= '0;
      pes_flags <= '0;
      pts_raw <= '0;
      pts_centis <= '0;
      pts_bad <= 1'b0;
      substream <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        parse_byte(s_tdata, got, r);
        if (typed_row) begin
          if (!got) begin
            $error("kind: expected %0d, actual no result predicted", typed_kind);
            failed = 1'b1;
          end
          expected_results.push_back(make_result(typed_kind, 8'h00, 8'h00, 1'b0));
        end else if (got) begin
          expected_results.push_back(r);
        end
      end
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected transaction: kind %0d tdata %h", m_tuser, m_tdata);
          failed = 1'b1;
        end else begin
          exp_r = expected_results.pop_front();
          if (m_tuser !== exp_r.kind) begin
            $error("kind: expected %0d, actual %0d", exp_r.kind, m_tuser);
            failed = 1'b1;
          end
          if (m_tdata[7:0] !== exp_r.payload_byte) begin
            $error("payload_byte: expected %h, actual %h", exp_r.payload_byte, m_tdata[7:0]);
            failed = 1'b1;
          end
          if (m_tdata[15:8] !== exp_r.stream_id) begin
            $error("stream_id: expected %h, actual %h", exp_r.stream_id, m_tdata[15:8]);
            failed = 1'b1;
          end
          if (m_tdata[38:16] !== exp_r.pts_centis) begin
            $error("pts_centis: expected %0d, actual %0d", exp_r.pts_centis, m_tdata[38:16]);
            failed = 1'b1;
          end
          if (m_tdata[39] !== exp_r.pts_marker_bad) begin
            $error("pts_marker_bad: expected %b, actual %b", exp_r.pts_marker_bad,
                   m_tdata[39]);
            failed = 1'b1;
          end
          if (m_tlast !== exp_r.last_of_packet) begin
            $error("last_of_packet: expected %b, actual %b", exp_r.last_of_packet, m_tlast);
            failed = 1'b1;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    m_tready <= rst ? 1'b0 : ($urandom_range(99) >= stall_pct);
  end

  task automatic send_byte(input logic [7:0] b, input logic typed, input psd_pkg::kind_t k);
    bit rdy;
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    typed_row <= typed;
    typed_kind <= k;
    do begin
      @(negedge clk);
      rdy = s_tready;
      @(posedge clk);
    end while (!rdy);
    bytes_sent++;
  endtask

  task automatic start_code(input logic [7:0] code);
    pkt_bytes.push_back(8'h00);
    pkt_bytes.push_back(8'h00);
    pkt_bytes.push_back(8'h01);
    pkt_bytes.push_back(code);
  endtask

  task automatic build_private_packet();
    int sel;
    int hdr_len;
    int n;
    int used;
    int plen;
    logic [7:0] flags;
    bit std_field;
    bit pts_flagged;
    std_field = ($urandom_range(3) == 0);
    used = std_field ? 5 : 3;
    sel = $urandom_range(9);
    flags = 8'($urandom_range(63));
    if (sel < 6) flags[7:6] = 2'b10;
    else if (sel < 8) flags[7:6] = 2'b11;
    else flags[7:6] = 2'($urandom_range(1));
    pts_flagged = flags[7:6] == 2'b10;
    hdr_len = pts_flagged ? 5 + $urandom_range(3) : $urandom_range(4);
    if ($urandom_range(19) == 0) hdr_len = $urandom_range(7);
    n = ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 16);
    plen = used + hdr_len + 1 + n;
    if ($urandom_range(11) == 0) plen = $urandom_range(used + hdr_len);
    if ($urandom_range(49) == 0) plen = plen | ($urandom_range(255) << 8);
    start_code(psd_pkg::CodePriv1);
    pkt_bytes.push_back(8'(plen >> 8));
    pkt_bytes.push_back(8'(plen));
    if (std_field) begin
      pkt_bytes.push_back(8'h40 | 8'($urandom_range(63)));
      pkt_bytes.push_back(8'($urandom_range(255)));
    end
    sel = $urandom_range(19);
    if (sel == 0) pkt_bytes.push_back(8'h20 | 8'($urandom_range(31)));
    else if (sel == 1) pkt_bytes.push_back($urandom_range(1) ? 8'h00 | 8'($urandom_range(31))
                                                              : 8'hc0 | 8'($urandom_range(63)));
    else pkt_bytes.push_back(8'h80 | 8'($urandom_range(63)));
    pkt_bytes.push_back(flags);
    pkt_bytes.push_back(8'(hdr_len));
    for (int i = 0; i < hdr_len; i++) begin
      if (pts_flagged && i < 5 && $urandom_range(4) != 0) begin
        case (i)
          0: pkt_bytes.push_back(8'h21 | 8'($urandom_range(15) & 14));
          2, 4: pkt_bytes.push_back(8'($urandom_range(255)) | 8'h01);
          default: pkt_bytes.push_back(8'($urandom_range(255)));
        endcase
      end else begin
        pkt_bytes.push_back(8'($urandom_range(255)));
      end
    end
    for (int i = 0; i <= n; i++) pkt_bytes.push_back(8'($urandom_range(255)));
  endtask

  task automatic build_item();
    int sel;
    int len;
    logic [7:0] code;
    sel = $urandom_range(99);
    if (sel < 55) begin
      build_private_packet();
    end else if (sel < 67) begin
      start_code(psd_pkg::CodePack);
      len = $urandom_range(9);
      if (len < 4) begin
        pkt_bytes.push_back(8'h40 | 8'($urandom_range(63)));
        len = 9;
      end else if (len < 8) begin
        pkt_bytes.push_back(8'h20 | 8'($urandom_range(15)));
        len = 7;
      end else begin
        pkt_bytes.push_back($urandom_range(1) ? 8'h80 | 8'($urandom_range(127))
                                              : 8'($urandom_range(31)));
        len = 0;
      end
      for (int i = 0; i < len; i++) pkt_bytes.push_back(8'($urandom_range(255)));
    end else if (sel < 80) begin
      code = $urandom_range(3) == 0 ? psd_pkg::CodePadding
                                    : 8'($urandom_range(8'hc0, 8'hef));
      start_code(code);
      len = ($urandom_range(39) == 0) ? $urandom_range(300) : $urandom_range(12);
      pkt_bytes.push_back(8'(len >> 8));
      pkt_bytes.push_back(8'(len));
      for (int i = 0; i < len; i++) pkt_bytes.push_back(8'($urandom_range(255)));
    end else if (sel < 84) begin
      start_code(psd_pkg::CodeEnd);
    end else if (sel < 92) begin
      do code = 8'($urandom_range(255));
      while (code == psd_pkg::CodeEnd || code == psd_pkg::CodePack ||
             code == psd_pkg::CodePriv1 || code == psd_pkg::CodePadding ||
             (code >= 8'hc0 && code < 8'hf0));
      start_code(code);
    end else begin
      len = $urandom_range(1, 8);
      for (int i = 0; i < len; i++) begin
        pkt_bytes.push_back($urandom_range(2) == 0 ? 8'($urandom_range(1)) : 8'($urandom_range(255)));
      end
    end
  endtask

  task automatic drain();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < DirRows; i++) begin
      send_byte(DirTab[i][7:0], DirTab[i][11], psd_pkg::kind_t'(DirTab[i][10:8]));
    end
    s_tvalid <= 1'b0;
    typed_row <= 1'b0;
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 80; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 80; end
        default: begin idle_pct = 28; stall_pct = 28; end
      endcase
      bytes_sent = 0;
      while (bytes_sent < 475) begin
        build_item();
        while (pkt_bytes.size() != 0) begin
          send_byte(pkt_bytes.pop_front(), 1'b0, psd_pkg::KIND_PAYLOAD);
        end
        if ($urandom_range(9) == 0) begin
          s_tvalid <= 1'b0;
          repeat ($urandom_range(1, 5)) @(posedge clk);
        end
      end
      s_tvalid <= 1'b0;
      drain();
    end
    if (!failed && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
